// ----- sv/cfpc_pkg.sv -----
// types and constants shared by the cooling fan pwm controller
// no dependencies
`default_nettype none

package cfpc_pkg;

    localparam int TEMP_W = 11;
    localparam int DUTY_W = 5;
    localparam int DIFF_W = TEMP_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = TEMP_W;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROPORTIONAL_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD     = 2'd3;

    localparam logic signed [TEMP_W-1:0] ON_THRESHOLD_RESET  = 11'sd368;
    localparam logic signed [TEMP_W-1:0] OFF_THRESHOLD_RESET = 11'sd352;

    // proportional mode: a distance below this gives full duty
    localparam logic signed [DIFF_W-1:0] FULL_DIFF_LIMIT = 12'sd2;

    typedef struct packed {
        logic                     sensor_enable;
        logic                     proportional_mode;
        logic signed [TEMP_W-1:0] on_threshold;
        logic signed [TEMP_W-1:0] off_threshold;
    } t_cfg;

    typedef struct packed {
        logic              fan_on;
        logic [DUTY_W-1:0] duty;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/cfpc_core.sv -----
// duty update and pwm sequencer state of the cooling fan controller
// depends on cfpc_pkg
`default_nettype none

module cfpc_core #(
    parameter int PWM_PERIOD_STEPS = 25
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_acc,
    input  wire logic                              i_cmd,
    input  wire logic signed [cfpc_pkg::TEMP_W-1:0] i_temperature,
    input  wire cfpc_pkg::t_cfg                    i_cfg,
    output cfpc_pkg::t_result                      o_res
);
    import cfpc_pkg::*;

    localparam logic [DUTY_W-1:0] LP_FULL = DUTY_W'(PWM_PERIOD_STEPS);
    localparam logic signed [DIFF_W-1:0] LP_DIFF_MAX = DIFF_W'(PWM_PERIOD_STEPS - 2);

    logic [DUTY_W-1:0] r_duty, n_duty;
    logic              r_phase, n_phase;
    logic [DUTY_W-1:0] r_ticks, n_ticks;
    logic              r_drive, n_drive;

    logic                     s_set;
    logic [DUTY_W-1:0]        s_dval;
    logic signed [DIFF_W-1:0] s_diff;

    assign s_diff = DIFF_W'(i_cfg.on_threshold) - DIFF_W'(i_temperature);

    always_comb begin
        s_set  = 1'b0;
        s_dval = r_duty;
        if (i_cfg.sensor_enable) begin
            if (!i_cfg.proportional_mode) begin
                // off wins when both thresholds hold
                if (i_temperature <= i_cfg.off_threshold) begin
                    s_set  = 1'b1;
                    s_dval = '0;
                end else if (i_temperature >= i_cfg.on_threshold) begin
                    s_set  = 1'b1;
                    s_dval = LP_FULL;
                end
            end else begin
                s_set = 1'b1;
                if (s_diff < FULL_DIFF_LIMIT) begin
                    s_dval = LP_FULL;
                end else if (s_diff > LP_DIFF_MAX) begin
                    s_dval = '0;
                end else begin
                    s_dval = LP_FULL - s_diff[DUTY_W-1:0];
                end
            end
        end
    end

    always_comb begin
        n_duty  = r_duty;
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_drive = r_drive;
        if (i_cmd == CMD_SAMPLE) begin
            if (s_set) begin
                n_duty = s_dval;
                if (s_dval == '0) begin
                    n_drive = 1'b0;
                end else if (s_dval >= LP_FULL) begin
                    n_drive = 1'b1;
                end
            end
        end else begin
            if (r_duty == '0) begin
                n_drive = 1'b0;
            end else if (r_duty >= LP_FULL) begin
                n_drive = 1'b1;
            end else if (r_ticks == '0) begin
                if (!r_phase) begin
                    n_phase = 1'b1;
                    n_drive = 1'b1;
                    n_ticks = r_duty - DUTY_W'(1);
                end else begin
                    n_phase = 1'b0;
                    n_drive = 1'b0;
                    n_ticks = LP_FULL - r_duty - DUTY_W'(1);
                end
            end else begin
                n_ticks = r_ticks - DUTY_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty  <= '0;
            r_phase <= 1'b0;
            r_ticks <= '0;
            r_drive <= 1'b0;
        end else if (i_acc) begin
            r_duty  <= n_duty;
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_drive <= n_drive;
        end
    end

    assign o_res.fan_on = n_drive;
    assign o_res.duty   = n_duty;

endmodule

`default_nettype wire

// ----- sv/cooling_fan_pwm_controller_top.sv -----
// cooling fan pwm controller: top level with config registers and output buffer
// depends on cfpc_pkg and cfpc_core
//
// usage
//   input channel: i_valid / o_stall carrying i_cmd and i_temperature. cmd 0 is a
//   coolant temperature sample, cmd 1 is one pwm tick. every item gives one result.
//   output channel: o_valid / i_stall carrying o_fan_on and o_duty, the fan drive
//   level and duty after that item.
//   config: i_cfg_we writes i_cfg_data into register i_cfg_idx (sensor enable,
//   proportional mode, on threshold, off threshold); write only while idle.
//   timing: the result is registered in the output register, or in the skid
//   entry if the output is stalled; one item per cycle is sustained while i_stall
//   is low, set by the single registered update of the duty and sequencer state.
//   reset: synchronous, active low; clears the pwm state, output buffer and
//   loads the default thresholds. a two-entry output buffer holds results while
//   i_stall is high; o_stall rises once both entries are full.
`default_nettype none

module cooling_fan_pwm_controller_top #(
    parameter int PWM_PERIOD_STEPS = 25
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [cfpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [cfpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_cmd,
    input  wire logic signed [cfpc_pkg::TEMP_W-1:0]  i_temperature,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_fan_on,
    output logic [cfpc_pkg::DUTY_W-1:0]              o_duty
);
    import cfpc_pkg::*;

    t_cfg    r_cfg;
    t_result s_res;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    s_in_acc, s_out_take;

    assign o_stall    = r_skid_valid;
    assign s_in_acc   = i_valid && !r_skid_valid;
    assign s_out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_enable     <= 1'b0;
            r_cfg.proportional_mode <= 1'b0;
            r_cfg.on_threshold      <= ON_THRESHOLD_RESET;
            r_cfg.off_threshold     <= OFF_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SENSOR_ENABLE:     r_cfg.sensor_enable     <= i_cfg_data[0];
                REG_PROPORTIONAL_MODE: r_cfg.proportional_mode <= i_cfg_data[0];
                REG_ON_THRESHOLD:      r_cfg.on_threshold      <= i_cfg_data;
                REG_OFF_THRESHOLD:     r_cfg.off_threshold     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cfpc_core #(
        .PWM_PERIOD_STEPS(PWM_PERIOD_STEPS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (s_in_acc),
        .i_cmd        (i_cmd),
        .i_temperature(i_temperature),
        .i_cfg        (r_cfg),
        .o_res        (s_res)
    );

    // output buffer: main register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (s_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (s_in_acc) begin
            if (r_out_valid && !s_out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (s_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (s_out_take) begin
                r_out <= r_skid;
            end
        end else if (s_in_acc) begin
            if (r_out_valid && !s_out_take) begin
                r_skid <= s_res;
            end else begin
                r_out <= s_res;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_fan_on = r_out.fan_on;
    assign o_duty   = r_out.duty;

endmodule

`default_nettype wire

// ----- sv/cfpc_checker.sv -----
// port-level checks for the cooling fan pwm controller, bound to the top level
// depends on cfpc_pkg and cooling_fan_pwm_controller_top
`default_nettype none

module cfpc_port_checks #(
    parameter int PWM_PERIOD_STEPS = 25
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_stall,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic                           o_fan_on,
    input wire logic [cfpc_pkg::DUTY_W-1:0]    o_duty
);
    import cfpc_pkg::*;

    localparam logic [DUTY_W-1:0] LP_FULL = DUTY_W'(PWM_PERIOD_STEPS);

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_duty <= LP_FULL)
        else $error("duty above pwm period");

    a_off_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_duty == '0) |-> !o_fan_on)
        else $error("fan driven at zero duty");

    a_on_at_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_duty == LP_FULL) |-> o_fan_on)
        else $error("fan not driven at full duty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_duty) && $stable(o_fan_on)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("buffer not empty after reset");

endmodule

bind cooling_fan_pwm_controller_top cfpc_port_checks #(
    .PWM_PERIOD_STEPS(PWM_PERIOD_STEPS)
) u_cfpc_port_checks (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_fan_on(o_fan_on),
    .o_duty  (o_duty)
);

`default_nettype wire

// ----- sim/cfpc_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the cooling fan pwm controller: tracks register writes, predicts
// fan drive level and duty for every accepted item and compares each result
// depends on cfpc_pkg
module cfpc_checker #(
    parameter int PWM_PERIOD_STEPS = 25
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [cfpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [cfpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire logic                               i_cmd,
    input  wire logic signed [cfpc_pkg::TEMP_W-1:0] i_temperature,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_fan_on,
    input  wire logic [cfpc_pkg::DUTY_W-1:0]        i_duty,
    output int                                      o_fail_count,
    output int                                      o_pending,
    output int                                      o_checked
);
    import cfpc_pkg::*;

    logic                     sensor_en;
    logic                     prop_mode;
    logic signed [TEMP_W-1:0] on_thr;
    logic signed [TEMP_W-1:0] off_thr;

    logic [DUTY_W-1:0] duty_lvl;
    logic              phase_active;
    logic [DUTY_W-1:0] ticks_rem;
    logic              drive;

    t_result fan_expected_q[$];
    int      fail_tally = 0;
    int      checked_tally = 0;

    assign o_fail_count = fail_tally;
    assign o_checked    = checked_tally;

    task automatic apply_duty(input int d);
        duty_lvl = DUTY_W'(d);
        if (duty_lvl == '0) begin
            drive = 1'b0;
        end else if (int'(duty_lvl) >= PWM_PERIOD_STEPS) begin
            drive = 1'b1;
        end
    endtask

    task automatic advance_fan(input logic c, input logic signed [TEMP_W-1:0] t,
                               output t_result res);
        int temp_v;
        int diff;
        temp_v = $signed(t);
        if (c == CMD_SAMPLE) begin
            if (sensor_en) begin
                if (!prop_mode) begin
                    if (temp_v >= $signed(on_thr)) apply_duty(PWM_PERIOD_STEPS);
                    if (temp_v <= $signed(off_thr)) apply_duty(0);
                end else begin
                    diff = $signed(on_thr) - temp_v;
                    if (diff < 2) begin
                        apply_duty(PWM_PERIOD_STEPS);
                    end else if (diff > PWM_PERIOD_STEPS - 2) begin
                        apply_duty(0);
                    end else begin
                        apply_duty(PWM_PERIOD_STEPS - diff);
                    end
                end
            end
        end else begin
            if (duty_lvl == '0) begin
                drive = 1'b0;
            end else if (int'(duty_lvl) >= PWM_PERIOD_STEPS) begin
                drive = 1'b1;
            end else if (ticks_rem == '0) begin
                if (!phase_active) begin
                    phase_active = 1'b1;
                    drive        = 1'b1;
                    ticks_rem    = DUTY_W'(int'(duty_lvl) - 1);
                end else begin
                    phase_active = 1'b0;
                    drive        = 1'b0;
                    ticks_rem    = DUTY_W'(PWM_PERIOD_STEPS - int'(duty_lvl) - 1);
                end
            end else begin
                ticks_rem = ticks_rem - DUTY_W'(1);
            end
        end
        res.fan_on = drive;
        res.duty   = duty_lvl;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result res;
        if (!i_rst_n) begin
            sensor_en    = 1'b0;
            prop_mode    = 1'b0;
            on_thr       = ON_THRESHOLD_RESET;
            off_thr      = OFF_THRESHOLD_RESET;
            duty_lvl     = '0;
            phase_active = 1'b0;
            ticks_rem    = '0;
            drive        = 1'b0;
            fan_expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.fan_on = i_fan_on;
                got.duty   = i_duty;
                if (fan_expected_q.size() == 0) begin
                    fail_tally++;
                    $display("%0t: result with nothing expected, got fan_on %0b duty %0d",
                             $time, got.fan_on, got.duty);
                end else begin
                    want = fan_expected_q.pop_front();
                    checked_tally++;
                    if (got.fan_on !== want.fan_on) begin
                        fail_tally++;
                        $display("%0t: fan_on mismatch, expected %0b, got %0b",
                                 $time, want.fan_on, got.fan_on);
                    end
                    if (got.duty !== want.duty) begin
                        fail_tally++;
                        $display("%0t: duty mismatch, expected %0d, got %0d",
                                 $time, want.duty, got.duty);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_fan(i_cmd, i_temperature, res);
                fan_expected_q.push_back(res);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SENSOR_ENABLE:     sensor_en = i_cfg_data[0];
                    REG_PROPORTIONAL_MODE: prop_mode = i_cfg_data[0];
                    REG_ON_THRESHOLD:      on_thr    = i_cfg_data[TEMP_W-1:0];
                    REG_OFF_THRESHOLD:     off_thr   = i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= fan_expected_q.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for the cooling fan pwm controller: clock, reset, register settings,
// temperature samples and pwm ticks, output stalls and the verdict
// depends on cfpc_pkg, cooling_fan_pwm_controller_top and cfpc_checker
module tb_top;
    import cfpc_pkg::*;

    localparam int PERIOD_STEPS    = 25;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int HOLD_CYCLES     = 60;
    localparam int LIMIT_CYCLES    = 200000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = CMD_SAMPLE;
    logic signed [TEMP_W-1:0] temperature = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     fan_on;
    logic [DUTY_W-1:0]        duty;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int item_count = 0;
    int settings_count = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    always #1 clk = ~clk;

    cooling_fan_pwm_controller_top #(
        .PWM_PERIOD_STEPS(PERIOD_STEPS)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_cmd        (cmd),
        .i_temperature(temperature),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_fan_on     (fan_on),
        .o_duty       (duty)
    );

    cfpc_checker #(
        .PWM_PERIOD_STEPS(PERIOD_STEPS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_cmd        (cmd),
        .i_temperature(temperature),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_fan_on     (fan_on),
        .i_duty       (duty),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= idle_on && ($urandom_range(99) < 24);
            end
        end
    end

    function automatic int clamp_temp(input int v);
        if (v > 1023) return 1023;
        if (v < -1024) return -1024;
        return v;
    endfunction

    task automatic send_item(input logic c, input int t);
        if (idle_on && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        temperature <= TEMP_W'(t);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        item_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_settings(input logic en, input logic prop, input int on_t,
                                 input int off_t);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_SENSOR_ENABLE;
        cfg_data <= CFG_DATA_W'(en);
        @(posedge clk);
        cfg_idx  <= REG_PROPORTIONAL_MODE;
        cfg_data <= CFG_DATA_W'(prop);
        @(posedge clk);
        cfg_idx  <= REG_ON_THRESHOLD;
        cfg_data <= CFG_DATA_W'(on_t);
        @(posedge clk);
        cfg_idx  <= REG_OFF_THRESHOLD;
        cfg_data <= CFG_DATA_W'(off_t);
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_count++;
    endtask

    initial begin
        int  on_t;
        int  off_t;
        int  base;
        int  tick_pct;
        int  t;
        logic en;
        logic prop;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sensor disabled after reset: samples ignored, ticks at duty 0
        send_item(CMD_SAMPLE, 1023);
        send_item(CMD_TICK, 0);

        // on/off hysteresis with default thresholds
        load_settings(1'b1, 1'b0, 368, 352);
        send_item(CMD_SAMPLE, 368);
        send_item(CMD_TICK, 0);
        send_item(CMD_SAMPLE, 360);
        send_item(CMD_SAMPLE, 352);
        send_item(CMD_TICK, 0);
        send_item(CMD_SAMPLE, 1023);
        send_item(CMD_SAMPLE, -1024);

        // overlapping thresholds: off wins
        load_settings(1'b1, 1'b0, 100, 200);
        send_item(CMD_SAMPLE, 250);
        send_item(CMD_SAMPLE, 150);

        // proportional: full duty, intermediate duty with pwm, zero duty
        load_settings(1'b1, 1'b1, 368, 352);
        send_item(CMD_SAMPLE, 367);
        send_item(CMD_SAMPLE, 366);
        repeat (3) send_item(CMD_TICK, 0);
        send_item(CMD_SAMPLE, 345);
        repeat (3) send_item(CMD_TICK, 0);
        send_item(CMD_SAMPLE, 344);
        send_item(CMD_SAMPLE, 355);
        send_item(CMD_TICK, 0);

        // widest differences
        load_settings(1'b1, 1'b1, -1024, 1023);
        send_item(CMD_SAMPLE, 1023);
        load_settings(1'b1, 1'b1, 1023, -1024);
        send_item(CMD_SAMPLE, -1024);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    on_t  = 1023;
                    off_t = -1024;
                end
                1: begin
                    on_t  = -1024;
                    off_t = 1023;
                end
                default: begin
                    on_t = int'($urandom_range(2047)) - 1024;
                    if ($urandom_range(3) == 0) begin
                        off_t = int'($urandom_range(2047)) - 1024;
                    end else begin
                        off_t = clamp_temp(on_t - int'($urandom_range(40)));
                    end
                end
            endcase
            en   = (ph == 2) ? 1'b0 : (ph < 2 || $urandom_range(5) != 0);
            prop = (ph < 2) ? ph[0] : 1'($urandom_range(1));
            load_settings(en, prop, on_t, off_t);
            idle_on  = (ph != 3);
            tick_pct = $urandom_range(50, 90);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 5 && k == 40) begin
                    hold_req = 1'b1;
                    idle_on  = 1'b0;
                end
                if (ph == 5 && k == 60) idle_on = 1'b1;
                if (ph == 6 && k == 90) drain_results();
                if ($urandom_range(99) < tick_pct) begin
                    send_item(CMD_TICK, int'($urandom_range(2047)) - 1024);
                end else begin
                    base = $urandom_range(1) ? on_t : off_t;
                    if ($urandom_range(3) == 0) begin
                        t = int'($urandom_range(2047)) - 1024;
                    end else begin
                        t = clamp_temp(base + int'($urandom_range(60)) - 30);
                    end
                    send_item(CMD_SAMPLE, t);
                end
            end
        end
        idle_on = 1'b1;

        drain_results();
        repeat (4) @(posedge clk);
        $display("run covered %0d samples and pwm ticks under %0d register settings",
                 item_count, settings_count);
        $display("%0d results compared, %0d failures", checked, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
